### rtl/bcgc_pkg.sv
// ----------------------------------------------------------------------------
// Button click gesture classifier package
// Shared types, gesture codes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bcgc_pkg;

    localparam int unsigned TIMER_BITS_DEFAULT = 16;
    localparam int unsigned CFG_DATA_BITS      = 16;
    localparam int unsigned CFG_INDEX_BITS     = 2;
    localparam int unsigned ELAPSED_BITS       = 8;

    localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_RESET       = 16'd1000;
    localparam logic [CFG_DATA_BITS-1:0] SUPER_LONG_PRESS_RESET = 16'd3000;
    localparam logic [CFG_DATA_BITS-1:0] ULTRA_LONG_PRESS_RESET = 16'd6000;
    localparam logic [CFG_DATA_BITS-1:0] CLICK_WAIT_RESET       = 16'd300;

    typedef enum logic [2:0] {
        GEST_NONE   = 3'd0,
        GEST_CAPT   = 3'd1,
        GEST_SINGLE = 3'd2,
        GEST_DOUBLE = 3'd3,
        GEST_TRIPLE = 3'd4,
        GEST_LONG   = 3'd5,
        GEST_SUPER  = 3'd6,
        GEST_ULTRA  = 3'd7
    } gesture_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LONG_PRESS       = 2'd0,
        CFG_SUPER_LONG_PRESS = 2'd1,
        CFG_ULTRA_LONG_PRESS = 2'd2,
        CFG_CLICK_WAIT       = 2'd3
    } cfg_index_t;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_BEGIN = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t                kind;
        logic                      button_pressed;
        logic [ELAPSED_BITS-1:0]   elapsed_ms;
    } item_t;

    typedef struct packed {
        gesture_t confirmed_gesture;
        gesture_t current_gesture;
        logic     capturing;
    } result_t;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] long_press_ms;
        logic [CFG_DATA_BITS-1:0] super_long_press_ms;
        logic [CFG_DATA_BITS-1:0] ultra_long_press_ms;
        logic [CFG_DATA_BITS-1:0] click_wait_ms;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/bcgc_if.sv
// ----------------------------------------------------------------------------
// Button click gesture classifier channels
// Valid/ready interfaces for input items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcgc_item_if
    import bcgc_pkg::*;
();
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bcgc_result_if
    import bcgc_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bcgc_cfg_if
    import bcgc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/button_click_gesture_classifier.sv
// ----------------------------------------------------------------------------
// Button click gesture classifier
// Classifies clicks and long presses from a stream of button samples.
// ----------------------------------------------------------------------------
// The items channel carries begin beats, which start a capture, and tick
// beats with the sampled button level and the milliseconds elapsed. Every
// accepted beat produces exactly one beat on the results channel with the
// confirmed gesture, the gesture seen so far and the capturing flag.
// The cfg channel writes the four threshold registers; it is always ready
// and should only be used while no beat is in flight.
// A result is registered at the clock edge that accepts its item. Throughput
// is one item per cycle while the results channel is ready, set by the single
// result register after the classification logic.
// When the receiver stalls, the result register holds its beat and the items
// channel is not ready until that beat is taken. A new item is accepted in
// the same cycle as the waiting result leaves, so no cycle is lost.
// Reset clears the gesture state, the edge timer and the result valid flag and
// loads the thresholds with 1000, 3000, 6000 and 300 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_gesture_classifier
    import bcgc_pkg::*;
#(
    parameter int unsigned TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    bcgc_item_if.sink      items,
    bcgc_result_if.source  results,
    bcgc_cfg_if.sink       cfg
);

    cfg_t    regs;
    result_t step_result;
    logic    in_ready;
    logic    step_en;

    assign items.ready = in_ready;
    assign step_en     = items.valid && in_ready;

    bcgc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    bcgc_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (items.payload),
        .regs    (regs),
        .result  (step_result)
    );

    bcgc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (in_ready),
        .in_result (step_result),
        .results   (results)
    );

endmodule

`default_nettype wire

### rtl/bcgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Button click gesture classifier register file
// Holds the four threshold registers written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module bcgc_cfg_regs
    import bcgc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bcgc_cfg_if.sink   cfg,
    output cfg_t       regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_LONG_PRESS:       regs_next.long_press_ms       = cfg.data;
                CFG_SUPER_LONG_PRESS: regs_next.super_long_press_ms = cfg.data;
                CFG_ULTRA_LONG_PRESS: regs_next.ultra_long_press_ms = cfg.data;
                CFG_CLICK_WAIT:       regs_next.click_wait_ms       = cfg.data;
                default:              regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.long_press_ms       <= LONG_PRESS_RESET;
            regs_reg.super_long_press_ms <= SUPER_LONG_PRESS_RESET;
            regs_reg.ultra_long_press_ms <= ULTRA_LONG_PRESS_RESET;
            regs_reg.click_wait_ms       <= CLICK_WAIT_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

### rtl/bcgc_core.sv
// ----------------------------------------------------------------------------
// Button click gesture classifier core
// Gesture state, edge timer and the combinational classification step.
// ----------------------------------------------------------------------------
`default_nettype none

module bcgc_core
    import bcgc_pkg::*;
#(
    parameter int unsigned TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step_en,
    input  item_t        item,
    input  cfg_t         regs,
    output result_t      result
);

    localparam int unsigned CMP_BITS =
        (TIMER_BITS > CFG_DATA_BITS) ? TIMER_BITS : CFG_DATA_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic                  last_level_reg;
    logic                  last_level_next;
    gesture_t              confirmed_reg;
    gesture_t              confirmed_next;
    gesture_t              current_reg;
    gesture_t              current_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;

    logic [TIMER_BITS:0]   timer_sum;
    logic [CMP_BITS-1:0]   timer_cmp;
    logic                  rise;
    logic                  fall;

    assign timer_sum = {1'b0, timer_reg} + (TIMER_BITS+1)'(item.elapsed_ms);
    assign rise      = !last_level_reg && item.button_pressed;
    assign fall      = last_level_reg && !item.button_pressed;
    assign timer_cmp = CMP_BITS'(timer_next);

    always_comb
    begin
        last_level_next = item.button_pressed;
        confirmed_next  = confirmed_reg;
        current_next    = current_reg;
        timer_next      = timer_reg;

        if (item.kind == KIND_BEGIN)
        begin
            confirmed_next = item.button_pressed ? GEST_CAPT : GEST_NONE;
            current_next   = item.button_pressed ? GEST_SINGLE : GEST_NONE;
            timer_next     = '0;
        end
        else
        begin
            timer_next = timer_sum[TIMER_BITS] ? TIMER_MAX : timer_sum[TIMER_BITS-1:0];
            if (confirmed_reg == GEST_CAPT)
            begin
                if (rise || fall)
                begin
                    timer_next = '0;
                end
                if (rise)
                begin
                    case (current_reg)
                        GEST_SINGLE: current_next = GEST_DOUBLE;
                        GEST_DOUBLE: current_next = GEST_TRIPLE;
                        default:     current_next = current_reg;
                    endcase
                end
                if (item.button_pressed)
                begin
                    case (current_next)
                        GEST_SINGLE:
                        begin
                            if (timer_cmp >= CMP_BITS'(regs.long_press_ms))
                                current_next = GEST_LONG;
                        end
                        GEST_LONG:
                        begin
                            if (timer_cmp >= CMP_BITS'(regs.super_long_press_ms))
                                current_next = GEST_SUPER;
                        end
                        GEST_SUPER:
                        begin
                            if (timer_cmp >= CMP_BITS'(regs.ultra_long_press_ms))
                                current_next = GEST_ULTRA;
                        end
                        default:
                        begin
                            current_next = current_next;
                        end
                    endcase
                end
                else if (timer_cmp >= CMP_BITS'(regs.click_wait_ms))
                begin
                    confirmed_next = current_next;
                end
            end
        end
    end

    assign result.confirmed_gesture = confirmed_next;
    assign result.current_gesture   = current_next;
    assign result.capturing         = (confirmed_next == GEST_CAPT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b0;
            confirmed_reg  <= GEST_NONE;
            current_reg    <= GEST_NONE;
            timer_reg      <= '0;
        end
        else if (step_en)
        begin
            last_level_reg <= last_level_next;
            confirmed_reg  <= confirmed_next;
            current_reg    <= current_next;
            timer_reg      <= timer_next;
        end
    end

`ifndef SYNTHESIS
    a_begin_released_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.kind == KIND_BEGIN && !item.button_pressed
        |=> confirmed_reg == GEST_NONE && current_reg == GEST_NONE && timer_reg == '0)
        else $error("begin with button released did not clear the gesture");

    a_capture_has_gesture: assert property (@(posedge clk) disable iff (!rst_n)
        confirmed_reg == GEST_CAPT
        |-> current_reg != GEST_NONE && current_reg != GEST_CAPT)
        else $error("capture running without a current gesture");

    a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(timer_reg) && $stable(current_reg) && $stable(confirmed_reg))
        else $error("gesture state changed without an accepted item");
`endif

endmodule

`default_nettype wire

### rtl/bcgc_out_stage.sv
// ----------------------------------------------------------------------------
// Button click gesture classifier output stage
// Result register that decouples the result channel from the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bcgc_out_stage
    import bcgc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  result_t        in_result,
    bcgc_result_if.source  results
);

    logic    valid_reg;
    logic    valid_next;
    result_t payload_reg;

    assign in_ready        = !valid_reg || results.ready;
    assign results.valid   = valid_reg;
    assign results.payload = payload_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            payload_reg <= in_result;
        end
    end

endmodule

`default_nettype wire

### bench/button_click_gesture_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click gesture classifier testbench
// Sends begin and tick beats to the classifier under several threshold
// settings and checks every result beat against a cycle-free model of the
// gesture state kept alongside the run. Both channels idle at random in most phases.
// ----------------------------------------------------------------------------

module button_click_gesture_classifier_tb;

    import bcgc_pkg::*;

    localparam int unsigned TIMER_BITS   = TIMER_BITS_DEFAULT;
    localparam int unsigned REPORT_LIMIT = 10;

    logic clk = 1'b0;
    logic rst_n;

    bcgc_item_if   items_ch ();
    bcgc_result_if results_ch ();
    bcgc_cfg_if    cfg_ch ();

    button_click_gesture_classifier #(
        .TIMER_BITS (TIMER_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [CFG_DATA_BITS-1:0] thr_long  = LONG_PRESS_RESET;
    logic [CFG_DATA_BITS-1:0] thr_super = SUPER_LONG_PRESS_RESET;
    logic [CFG_DATA_BITS-1:0] thr_ultra = ULTRA_LONG_PRESS_RESET;
    logic [CFG_DATA_BITS-1:0] thr_wait  = CLICK_WAIT_RESET;

    logic                  model_level     = 1'b0;
    gesture_t              model_confirmed = GEST_NONE;
    gesture_t              model_current   = GEST_NONE;
    logic [TIMER_BITS-1:0] model_timer     = '0;

    item_t       pending_samples[$];
    result_t     expected_gestures[$];
    int unsigned queued_count       = 0;
    int unsigned gesture_mismatches = 0;
    bit          idle_enable        = 1'b1;
    int unsigned send_gap           = 0;
    int unsigned stall_left         = 0;

    function automatic result_t classify_sample(item_t s);
        logic                prev;
        logic [TIMER_BITS:0] sum;
        result_t             r;
        if (s.kind == KIND_BEGIN)
        begin
            model_confirmed = s.button_pressed ? GEST_CAPT : GEST_NONE;
            model_current   = s.button_pressed ? GEST_SINGLE : GEST_NONE;
            model_level     = s.button_pressed;
            model_timer     = '0;
        end
        else
        begin
            prev        = model_level;
            sum         = {1'b0, model_timer} + (TIMER_BITS+1)'(s.elapsed_ms);
            model_timer = sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];
            model_level = s.button_pressed;
            if (model_confirmed == GEST_CAPT)
            begin
                if (!prev && s.button_pressed)
                begin
                    model_timer = '0;
                    if (model_current == GEST_SINGLE)
                        model_current = GEST_DOUBLE;
                    else if (model_current == GEST_DOUBLE)
                        model_current = GEST_TRIPLE;
                end
                if (prev && !s.button_pressed)
                    model_timer = '0;
                if (s.button_pressed)
                begin
                    if (model_current == GEST_SINGLE)
                    begin
                        if (model_timer >= thr_long)
                            model_current = GEST_LONG;
                    end
                    else if (model_current == GEST_LONG)
                    begin
                        if (model_timer >= thr_super)
                            model_current = GEST_SUPER;
                    end
                    else if (model_current == GEST_SUPER)
                    begin
                        if (model_timer >= thr_ultra)
                            model_current = GEST_ULTRA;
                    end
                end
                if (!s.button_pressed && model_timer >= thr_wait)
                    model_confirmed = model_current;
            end
        end
        r.confirmed_gesture = model_confirmed;
        r.current_gesture   = model_current;
        r.capturing         = (model_confirmed == GEST_CAPT);
        return r;
    endfunction

    // Sender: one beat is offered at a time and the model advances when it is taken.
    initial
    begin
        items_ch.valid   = 1'b0;
        items_ch.payload = '0;
        results_ch.ready = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_LONG_PRESS;
        cfg_ch.data      = '0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            items_ch.valid <= 1'b0;
        end
        else
        begin
            if (items_ch.valid && items_ch.ready)
                expected_gestures.push_back(classify_sample(items_ch.payload));
            if (!items_ch.valid || items_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    items_ch.valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    items_ch.valid   <= 1'b1;
                    items_ch.payload <= pending_samples.pop_front();
                    if (idle_enable && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 4);
                end
                else
                begin
                    items_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(string what, result_t want, result_t got);
        gesture_mismatches++;
        if (gesture_mismatches <= REPORT_LIMIT)
            $display("%0t: %s: expected confirmed %0d current %0d capturing %0d, got %0d %0d %0d",
                     $realtime, what, want.confirmed_gesture, want.current_gesture,
                     want.capturing, got.confirmed_gesture, got.current_gesture, got.capturing);
    endtask

    // Receiver: checks each result beat and stalls in short bursts.
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            results_ch.ready <= 1'b0;
        end
        else
        begin
            if (results_ch.valid && results_ch.ready)
            begin
                if (expected_gestures.size() == 0)
                begin
                    note_mismatch("result with nothing pending", '0, results_ch.payload);
                end
                else
                begin
                    want = expected_gestures.pop_front();
                    if (results_ch.payload.confirmed_gesture !== want.confirmed_gesture
                        || results_ch.payload.current_gesture !== want.current_gesture
                        || results_ch.payload.capturing !== want.capturing)
                        note_mismatch("gesture mismatch", want, results_ch.payload);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                results_ch.ready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                results_ch.ready <= 1'b0;
            end
            else
            begin
                results_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [ELAPSED_BITS-1:0] random_elapsed();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return ELAPSED_BITS'($urandom_range(0, 255));
    endfunction

    task automatic push_sample(item_kind_t kind, logic level, logic [ELAPSED_BITS-1:0] ms);
        item_t s;
        s.kind           = kind;
        s.button_pressed = level;
        s.elapsed_ms     = ms;
        pending_samples.push_back(s);
        queued_count++;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || items_ch.valid || expected_gestures.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_threshold(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_LONG_PRESS:       thr_long  = value;
            CFG_SUPER_LONG_PRESS: thr_super = value;
            CFG_ULTRA_LONG_PRESS: thr_ultra = value;
            CFG_CLICK_WAIT:       thr_wait  = value;
            default: ;
        endcase
    endtask

    task automatic program_thresholds(logic [CFG_DATA_BITS-1:0] long_ms,
                                      logic [CFG_DATA_BITS-1:0] super_ms,
                                      logic [CFG_DATA_BITS-1:0] ultra_ms,
                                      logic [CFG_DATA_BITS-1:0] wait_ms);
        wait_drained();
        write_threshold(CFG_LONG_PRESS, long_ms);
        write_threshold(CFG_SUPER_LONG_PRESS, super_ms);
        write_threshold(CFG_ULTRA_LONG_PRESS, ultra_ms);
        write_threshold(CFG_CLICK_WAIT, wait_ms);
    endtask

    // A press, then optional further clicks, then a release of one to six ticks.
    task automatic queue_gesture(int unsigned hold_max);
        int unsigned clicks;
        int unsigned n;
        push_sample(KIND_BEGIN, 1'b1, ELAPSED_BITS'($urandom_range(0, 255)));
        clicks = $urandom_range(0, 4);
        for (int k = 0; k <= clicks; k++)
        begin
            if (k != 0)
            begin
                n = $urandom_range(1, 3);
                for (int j = 0; j < n; j++)
                    push_sample(KIND_TICK, 1'b0, random_elapsed());
            end
            n = $urandom_range(0, hold_max);
            for (int j = 0; j < n; j++)
                push_sample(KIND_TICK, 1'b1, random_elapsed());
        end
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++)
            push_sample(KIND_TICK, 1'b0, random_elapsed());
    endtask

    task automatic queue_mix(int unsigned target, int unsigned hold_max);
        int unsigned start;
        start = queued_count;
        while (queued_count - start < target)
        begin
            if ($urandom_range(0, 9) < 7)
                queue_gesture(hold_max);
            else
                repeat ($urandom_range(1, 3))
                    push_sample($urandom_range(0, 3) == 0 ? KIND_BEGIN : KIND_TICK,
                                1'($urandom_range(0, 1)),
                                ELAPSED_BITS'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset thresholds: ticks outside a capture, a begin with the button up,
        // a hold into long press, and clicks past triple.
        push_sample(KIND_TICK, 1'b1, 8'd0);
        push_sample(KIND_BEGIN, 1'b0, 8'd255);
        push_sample(KIND_TICK, 1'b1, 8'd255);
        push_sample(KIND_BEGIN, 1'b1, 8'd0);
        repeat (4) push_sample(KIND_TICK, 1'b1, 8'd255);
        repeat (3) push_sample(KIND_TICK, 1'b0, 8'd255);
        push_sample(KIND_BEGIN, 1'b1, 8'd17);
        for (int k = 0; k < 3; k++)
        begin
            push_sample(KIND_TICK, 1'b0, 8'd100);
            push_sample(KIND_TICK, 1'b1, 8'd40);
        end
        push_sample(KIND_TICK, 1'b0, 8'd200);
        push_sample(KIND_TICK, 1'b0, 8'd200);
        push_sample(KIND_TICK, 1'b0, 8'd1);
        queue_mix(30, 40);

        idle_enable = 1'b0;
        program_thresholds('0, '0, '0, '0);
        queue_mix(30, 4);

        idle_enable = 1'b1;
        program_thresholds(CFG_DATA_BITS'($urandom_range(0, 1500)),
                           CFG_DATA_BITS'($urandom_range(0, 1500)),
                           CFG_DATA_BITS'($urandom_range(0, 1500)),
                           CFG_DATA_BITS'($urandom_range(0, 1500)));
        queue_mix(30, 12);
        wait_drained();
        queue_mix(20, 12);

        program_thresholds(CFG_DATA_BITS'($urandom_range(0, 65535)),
                           CFG_DATA_BITS'($urandom_range(0, 65535)),
                           CFG_DATA_BITS'($urandom_range(0, 65535)),
                           CFG_DATA_BITS'($urandom_range(0, 65535)));
        queue_mix(30, 12);

        // All thresholds at the top: only a timer at its maximum can reach them.
        program_thresholds('1, '1, '1, '1);
        push_sample(KIND_BEGIN, 1'b1, 8'd0);
        push_sample(KIND_TICK, 1'b1, 8'd100);
        repeat (262) push_sample(KIND_TICK, 1'b1, 8'd255);
        repeat (3) push_sample(KIND_TICK, 1'b0, 8'd255);
        queue_mix(20, 6);

        program_thresholds(CFG_DATA_BITS'($urandom_range(0, 1000)),
                           CFG_DATA_BITS'($urandom_range(0, 2000)),
                           CFG_DATA_BITS'($urandom_range(0, 3000)),
                           CFG_DATA_BITS'($urandom_range(0, 600)));
        wait_drained();
        idle_enable = 1'b0;
        queue_mix(30, 10);

        wait_drained();
        repeat (5) @(posedge clk);
        if (gesture_mismatches == 0)
            $display("[button_click_gesture_classifier] OK");
        else
            $display("[button_click_gesture_classifier] ERROR");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("[button_click_gesture_classifier] ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/bcgc_pkg.sv
rtl/bcgc_if.sv
rtl/bcgc_cfg_regs.sv
rtl/bcgc_core.sv
rtl/bcgc_out_stage.sv
rtl/button_click_gesture_classifier.sv
bench/button_click_gesture_classifier_tb.sv
